[sv/lphm_pkg.sv]
`default_nettype none
package lphm_pkg;
    localparam int SLOT_COUNT_DEFAULT = 1024;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] LOAD_LIMIT_RESET = 11'd768;
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    typedef struct packed {
        logic              is_set;
        logic [KEY_W-1:0]  key;
        logic [31:0]       hash;
        logic [VAL_W-1:0]  value;
    } req_t;
endpackage
`default_nettype wire

[sv/linear_probe_hash_map.sv]
`default_nettype none
// channel   | direction | signals
// request   | in        | start, busy, req_type, key_id, key_hash, value_in
// result    | out       | done, found, value_out, rejected, entry_count
// config    | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// the engine probes one slot at a time (read, then compare), p slots per request
// from an idle engine, a request passes the queue, then S_READ and S_CHECK per slot; done is registered
// a two-entry queue sits between the accept side and the probe engine; busy when full
// after reset the engine clears every slot of the slot store; requests queue meanwhile
// load_limit resets to 768; results are strobed for one cycle on done; no receiver stall
module linear_probe_hash_map #(
    parameter int SLOT_COUNT = lphm_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       req_type,
    input  wire logic [31:0]                key_id,
    input  wire logic [31:0]                key_hash,
    input  wire logic [31:0]                value_in,
    output logic                            done,
    output logic                            found,
    output logic [31:0]                     value_out,
    output logic                            rejected,
    output logic [lphm_pkg::CNT_W-1:0]      entry_count,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [0:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    logic [lphm_pkg::CNT_W-1:0] load_limit_reg;
    lphm_pkg::req_t             in_req;
    lphm_pkg::req_t             head;
    logic                       full;
    logic                       not_empty;
    logic                       pop;
    logic                       push;
    logic                       back_idle;

    assign pready = 1'b1;
    assign prdata = {{(32 - lphm_pkg::CNT_W){1'b0}}, load_limit_reg};
    assign busy   = full;
    assign push   = start && !full;
    assign in_req = '{is_set: req_type, key: key_id, hash: key_hash, value: value_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= lphm_pkg::LOAD_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            load_limit_reg <= pwdata[lphm_pkg::CNT_W-1:0];
        end
    end

    lphm_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .push_req(in_req), .full(full),
        .pop(pop), .not_empty(not_empty), .head(head));

    lphm_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .req_valid(not_empty), .req(head), .req_pop(pop),
        .load_limit(load_limit_reg), .idle(back_idle), .done(done), .found(found),
        .value_out(value_out), .rejected(rejected), .entry_count(entry_count));

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> back_idle) else $error("pop while engine busy");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !back_idle || !$past(back_idle)) else $error("spurious result");
    a_get_norej: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> value_out == '0) else $error("miss with value");
`endif
endmodule
`default_nettype wire

[sv/lphm_ram.sv]
`default_nettype none
module lphm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/lphm_front.sv]
`default_nettype none
// accepts requests into a two-entry queue
module lphm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lphm_pkg::req_t push_req,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output lphm_pkg::req_t      head
);
    lphm_pkg::req_t q_reg [2];
    logic           rd_ptr_reg;
    logic           wr_ptr_reg;
    logic [1:0]     cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
`endif
endmodule
`default_nettype wire

[sv/lphm_back.sv]
`default_nettype none
// probe engine: reads one slot, then compares it, before the next; clears the slot store after reset
module lphm_back #(
    parameter int SLOT_COUNT = lphm_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire lphm_pkg::req_t             req,
    output logic                            req_pop,
    input  wire logic [lphm_pkg::CNT_W-1:0] load_limit,
    output logic                            idle,
    output logic                            done,
    output logic                            found,
    output logic [lphm_pkg::VAL_W-1:0]      value_out,
    output logic                            rejected,
    output logic [lphm_pkg::CNT_W-1:0]      entry_count
);
    localparam int AW = $clog2(SLOT_COUNT);
    localparam int NW = AW + 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK} state_t;

    state_t                     state_reg;
    lphm_pkg::req_t             cur_reg;
    logic [AW-1:0]              idx_reg;
    logic [NW-1:0]              n_reg;
    logic [lphm_pkg::CNT_W-1:0] count_reg;
    logic                       done_reg;
    logic                       found_reg;
    logic                       rej_reg;
    logic [lphm_pkg::VAL_W-1:0] vout_reg;

    logic [lphm_pkg::KEY_W:0]   rd_slot;
    logic [lphm_pkg::KEY_W:0]   slot_wdata;
    logic [lphm_pkg::VAL_W-1:0] rd_val;
    logic                       clearing;
    logic                       we_slot;
    logic                       we_key;
    logic                       we_val;
    logic                       slot_v;
    logic                       hit;
    logic                       room;
    logic [AW-1:0]              idx_inc;
    logic [lphm_pkg::CNT_W:0]   count_plus;

    // slot word: valid bit on top of the key
    lphm_ram #(.WIDTH(lphm_pkg::KEY_W + 1), .DEPTH(SLOT_COUNT)) u_key (
        .clk(clk), .we(we_slot), .waddr(idx_reg), .wdata(slot_wdata),
        .raddr(idx_reg), .rdata(rd_slot));
    lphm_ram #(.WIDTH(lphm_pkg::VAL_W), .DEPTH(SLOT_COUNT)) u_val (
        .clk(clk), .we(we_val), .waddr(idx_reg), .wdata(cur_reg.value),
        .raddr(idx_reg), .rdata(rd_val));

    assign clearing   = (state_reg == S_CLEAR);
    assign slot_v     = rd_slot[lphm_pkg::KEY_W];
    assign hit        = slot_v && (rd_slot[lphm_pkg::KEY_W-1:0] == cur_reg.key);
    assign count_plus = {1'b0, count_reg} + 1'b1;
    assign room       = count_plus <= {1'b0, load_limit};
    assign idx_inc    = (idx_reg == AW'(SLOT_COUNT - 1)) ? '0 : idx_reg + 1'b1;
    assign we_val     = (state_reg == S_CHECK) && cur_reg.is_set
                        && (hit || (!slot_v && room));
    assign we_key     = (state_reg == S_CHECK) && cur_reg.is_set && !slot_v && room;
    assign we_slot    = we_key || clearing;
    assign slot_wdata = clearing ? '0 : {1'b1, cur_reg.key};
    assign req_pop    = (state_reg == S_IDLE) && req_valid;
    assign idle       = (state_reg == S_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign rejected    = rej_reg;
    assign value_out   = vout_reg;
    assign entry_count = count_reg;

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            cur_reg <= req;
        end
        if (state_reg == S_CHECK)
        begin
            vout_reg <= (hit && !cur_reg.is_set) ? rd_val : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            n_reg     <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_inc;
                    if (idx_reg == AW'(SLOT_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        idx_reg   <= AW'(req.hash % SLOT_COUNT);
                        n_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!slot_v || hit || n_reg == NW'(SLOT_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        found_reg <= hit;
                        rej_reg   <= cur_reg.is_set && !hit && !(!slot_v && room);
                        if (we_key)
                        begin
                            count_reg <= count_plus[lphm_pkg::CNT_W-1:0];
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("double result");
    a_found_rej: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(found_reg && rej_reg)) else $error("found and rejected");
    a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
        we_key |-> count_reg < load_limit) else $error("insert over limit");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req_pop) else $error("request taken while clearing");
`endif
endmodule
`default_nettype wire
